>>> sv/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int DW = 32 + FRACTION_BITS;

    typedef enum logic [3:0] {
        OP_FROM_INT = 4'd0,
        OP_TRUNC    = 4'd1,
        OP_ROUND    = 4'd2,
        OP_ADD      = 4'd3,
        OP_SUB      = 4'd4,
        OP_ADD_INT  = 4'd5,
        OP_SUB_INT  = 4'd6,
        OP_MUL      = 4'd7,
        OP_MUL_INT  = 4'd8,
        OP_DIV      = 4'd9,
        OP_DIV_INT  = 4'd10
    } func_t;

    typedef enum logic [1:0] {
        K_PASS = 2'd0,
        K_MUL  = 2'd1,
        K_MULI = 2'd2,
        K_DIV  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t          kind;
        logic           dz;
        logic           neg;
        logic [31:0]    res;
        logic [31:0]    a;
        logic [31:0]    b;
        logic [DW-1:0]  dividend;
        logic [31:0]    divisor;
    } item_t;

endpackage
`default_nettype wire

>>> sv/fpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_front (
    input  wire logic [3:0]   func,
    input  wire logic [31:0]  operand_a,
    input  wire logic [31:0]  operand_b,
    output fpa_pkg::item_t    item
);
    import fpa_pkg::*;

    localparam logic [33:0] TB34 = (34'd1 << FRACTION_BITS) - 34'd1;
    localparam logic [32:0] HALF = 33'd1 << (FRACTION_BITS - 1);

    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
    logic signed [33:0] a34;
    logic signed [33:0] tsum;
    logic signed [33:0] tsh;
    logic [32:0]        rsum;
    logic [32:0]        rq;
    logic [31:0]        bsh;

    always_comb
    begin
        mag_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
        mag_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;
        a34   = {{2{operand_a[31]}}, operand_a};
        tsum  = a34 + (operand_a[31] ? $signed(TB34) : 34'sd0);
        tsh   = tsum >>> FRACTION_BITS;
        rsum  = {1'b0, mag_a} + HALF;
        rq    = rsum >> FRACTION_BITS;
        bsh   = operand_b << FRACTION_BITS;

        item          = '0;
        item.kind     = K_PASS;
        item.a        = operand_a;
        item.b        = operand_b;
        item.neg      = operand_a[31] ^ operand_b[31];
        item.dz       = 1'b0;
        item.divisor  = mag_b;
        item.dividend = {{FRACTION_BITS{1'b0}}, mag_a};
        case (func)
            OP_FROM_INT: item.res = operand_a << FRACTION_BITS;
            OP_TRUNC:    item.res = tsh[31:0];
            OP_ROUND:    item.res = operand_a[31] ? (32'd0 - rq[31:0]) : rq[31:0];
            OP_ADD:      item.res = operand_a + operand_b;
            OP_SUB:      item.res = operand_a - operand_b;
            OP_ADD_INT:  item.res = operand_a + bsh;
            OP_SUB_INT:  item.res = operand_a - bsh;
            OP_MUL:      item.kind = K_MUL;
            OP_MUL_INT:  item.kind = K_MULI;
            OP_DIV:
            begin
                item.kind     = K_DIV;
                item.dz       = (operand_b == 32'd0);
                item.dividend = {mag_a, {FRACTION_BITS{1'b0}}};
            end
            OP_DIV_INT:
            begin
                item.kind = K_DIV;
                item.dz   = (operand_b == 32'd0);
            end
            default:     item.res = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/fpa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire fpa_pkg::item_t wdata,
    output      logic          q_full,
    output      logic          q_empty,
    input  wire logic          rd,
    output      fpa_pkg::item_t rdata
);
    import fpa_pkg::*;

    item_t       mem_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic        do_wr;
    logic        do_rd;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rdata   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

endmodule
`default_nettype wire

>>> sv/fpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire fpa_pkg::item_t q_data,
    output      logic           q_rd,
    output      logic           empty,
    input  wire logic           pop,
    output      logic [31:0]    result,
    output      logic           divide_by_zero
);
    import fpa_pkg::*;

    localparam logic [63:0] BIAS = (64'd1 << FRACTION_BITS) - 64'd1;

    typedef struct packed {
        logic           vld;
        kind_t          kind;
        logic           dz;
        logic           neg;
        logic [31:0]    res;
        logic [31:0]    rem;
        logic [DW-1:0]  dq;
        logic [31:0]    dvs;
    } stage_t;

    typedef struct packed {
        logic [31:0] res;
        logic        dz;
    } out_t;

    stage_t             st_reg  [DW+1];
    stage_t             st_next [DW+1];
    logic signed [63:0] prod_reg;
    out_t               ob_reg  [2];
    logic               owp_reg;
    logic               orp_reg;
    logic [1:0]         ocnt_reg;

    logic               out_full;
    logic               adv;
    logic               opush;
    logic               opop;
    logic signed [63:0] msum;
    logic signed [63:0] msh;
    logic [32:0]        tmp;
    logic               qbit;
    out_t               fin;

    assign out_full = (ocnt_reg == 2'd2);
    assign adv      = !st_reg[DW].vld || !out_full;
    assign q_rd     = adv;
    assign opush    = adv && st_reg[DW].vld;
    assign empty    = (ocnt_reg == 2'd0);
    assign opop     = pop && !empty;
    assign result         = ob_reg[orp_reg].res;
    assign divide_by_zero = ob_reg[orp_reg].dz;

    always_comb
    begin
        msum = prod_reg + (prod_reg[63] ? $signed(BIAS) : 64'sd0);
        msh  = msum >>> FRACTION_BITS;
        tmp  = 33'd0;
        qbit = 1'b0;

        st_next[0].vld  = !q_empty;
        st_next[0].kind = q_data.kind;
        st_next[0].dz   = q_data.dz;
        st_next[0].neg  = q_data.neg;
        st_next[0].res  = q_data.res;
        st_next[0].rem  = 32'd0;
        st_next[0].dq   = q_data.dividend;
        st_next[0].dvs  = q_data.divisor;

        for (int i = 1; i <= DW; i++)
        begin
            st_next[i] = st_reg[i-1];
            tmp  = {st_reg[i-1].rem, st_reg[i-1].dq[DW-1]};
            qbit = (tmp >= {1'b0, st_reg[i-1].dvs});
            st_next[i].rem = qbit ? (tmp[31:0] - st_reg[i-1].dvs) : tmp[31:0];
            st_next[i].dq  = {st_reg[i-1].dq[DW-2:0], qbit};
        end

        case (st_reg[0].kind)
            K_MUL:   st_next[1].res = msh[31:0];
            K_MULI:  st_next[1].res = prod_reg[31:0];
            default: st_next[1].res = st_reg[0].res;
        endcase

        fin.dz  = st_reg[DW].dz && (st_reg[DW].kind == K_DIV);
        fin.res = st_reg[DW].res;
        if (st_reg[DW].kind == K_DIV)
        begin
            if (st_reg[DW].dz)
                fin.res = 32'd0;
            else if (st_reg[DW].neg)
                fin.res = 32'd0 - st_reg[DW].dq[31:0];
            else
                fin.res = st_reg[DW].dq[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= $signed(q_data.a) * $signed(q_data.b);
        end
        if (opush)
        begin
            ob_reg[owp_reg] <= fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DW; i++)
            begin
                st_reg[i] <= '0;
            end
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            if (adv)
            begin
                for (int i = 0; i <= DW; i++)
                begin
                    st_reg[i] <= st_next[i];
                end
            end
            if (opush) owp_reg <= ~owp_reg;
            if (opop)  orp_reg <= ~orp_reg;
            ocnt_reg <= ocnt_reg + {1'b0, opush} - {1'b0, opop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg != 2'd3) else $error("result buffer count out of range");
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg[DW].vld && out_full && !opop) |=> st_reg[DW].vld)
        else $error("stalled beat dropped from last stage");
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && divide_by_zero) |-> (result == 32'd0))
        else $error("divide by zero with non-zero result");

endmodule
`default_nettype wire

>>> sv/fixed_point_alu.sv
`timescale 1ns / 1ps
// channel | signals                          | beat taken when
// in      | push, full, func, operand_a/b    | push && !full
// out     | empty, pop, result, divide_by_zero | pop && !empty
// One beat per cycle sustained unless the back pipeline stalls; every operation
// passes through the one-bit-per-stage divider pipeline before empty goes low.
// The multiplier result is registered and finished one stage later.
// Reset clears the queues and stage valid bits; no memory needs clearing.
// Full result buffer + valid last stage: back pipeline stalls, front queue fills.
`default_nettype none
module fixed_point_alu (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output      logic        full,
    input  wire logic [3:0]  func,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output      logic        empty,
    input  wire logic        pop,
    output      logic [31:0] result,
    output      logic        divide_by_zero
);
    import fpa_pkg::*;

    item_t  fitem;
    item_t  qitem;
    logic   q_empty;
    logic   q_rd;

    fpa_front u_front (
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .item      (fitem)
    );

    fpa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wdata   (fitem),
        .q_full  (full),
        .q_empty (q_empty),
        .rd      (q_rd),
        .rdata   (qitem)
    );

    fpa_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (qitem),
        .q_rd           (q_rd),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .divide_by_zero (divide_by_zero)
    );

endmodule
`default_nettype wire

>>> sim/fixed_point_alu_checker.sv
`timescale 1ns / 1ps
module fixed_point_alu_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [3:0]  func,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [31:0] result,
    input  wire logic        divide_by_zero,
    output int               errors,
    output int               pending
);
    import fpa_pkg::*;

    typedef struct {
        logic [31:0] value;
        logic        dz;
    } alu_out_t;

    alu_out_t expected_q[$];

    function automatic alu_out_t alu_compute(logic [3:0] f, logic [31:0] a_in,
                                             logic [31:0] b_in);
        alu_out_t    o;
        longint      a;
        longint      b;
        longint      one;
        longint      half;
        longint      r;
        a    = longint'(signed'(a_in));
        b    = longint'(signed'(b_in));
        one  = longint'(1) << FRACTION_BITS;
        half = longint'(1) << (FRACTION_BITS - 1);
        r    = 0;
        o.dz = 1'b0;
        case (f)
            OP_FROM_INT: r = a * one;
            OP_TRUNC:    r = a / one;
            OP_ROUND:    r = (a >= 0) ? (a + half) / one : (a - half) / one;
            OP_ADD:      r = a + b;
            OP_SUB:      r = a - b;
            OP_ADD_INT:  r = a + b * one;
            OP_SUB_INT:  r = a - b * one;
            OP_MUL:      r = (a * b) / one;
            OP_MUL_INT:  r = a * b;
            OP_DIV:
                if (b == 0) o.dz = 1'b1;
                else r = (a * one) / b;
            OP_DIV_INT:
                if (b == 0) o.dz = 1'b1;
                else r = a / b;
            default:     r = 0;
        endcase
        o.value = r[31:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alu_out_t e;
        if (!rst_n)
        begin
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (push && !full)
                expected_q.push_back(alu_compute(func, operand_a, operand_b));
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat result=%h dz=%b", $time, result,
                             divide_by_zero);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.value !== result || e.dz !== divide_by_zero)
                    begin
                        $display("%0t: mismatch expected result=%h dz=%b actual result=%h dz=%b",
                                 $time, e.value, e.dz, result, divide_by_zero);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

>>> sim/fixed_point_alu_tb.sv
`timescale 1ns / 1ps
module fixed_point_alu_tb;
    import fpa_pkg::*;

    localparam int N_RANDOM = 1300;
    localparam int QUIET_TAIL = 300;
    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [3:0]  func = '0;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] result;
    logic        divide_by_zero;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          pop_idling = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fixed_point_alu DUT (.*);

    fixed_point_alu_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("fixed_point_alu_tb: done, errors");
            $finish;
        end
    end

    initial
    begin : pop_side
        int n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop_idling && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 13);
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(0, 64)) - 32);
            4: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19)) << 14;
            5: return 32'($urandom_range(0, 65535)) - 32768;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_beat(logic [3:0] f, logic [31:0] a, logic [31:0] b);
        push      <= 1'b1;
        func      <= f;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    initial
    begin : push_side
        logic [31:0] edge_vals [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                       32'hffff_ffff, 32'h0000_2000};
        int i;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i <= 10; i++)
            send_beat(4'(i), edge_vals[i % 5], edge_vals[(i + 1) % 5]);
        send_beat(OP_DIV, 32'h0000_4000, 32'h0);
        send_beat(OP_DIV_INT, 32'h8000_0000, 32'h0);
        send_beat(OP_DIV_INT, 32'h8000_0000, 32'hffff_ffff);
        send_beat(OP_ROUND, 32'hffff_e000, 32'h0);
        send_beat(OP_ROUND, 32'h0000_1fff, 32'h0);
        send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_beat(4'd11, 32'h1234_5678, 32'h0);
        send_beat(4'd15, 32'hffff_ffff, 32'hffff_ffff);
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i < N_RANDOM - QUIET_TAIL && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 13);
                push <= 1'b0;
                repeat (n) @(posedge clk);
            end
            if (i == N_RANDOM - QUIET_TAIL) pop_idling = 1'b0;
            send_beat(($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                                   : 4'($urandom_range(0, 10)),
                      pick_operand(), pick_operand());
        end
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (FRACTION_BITS + 60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("fixed_point_alu_tb: done, clean");
        else
            $display("fixed_point_alu_tb: done, errors");
        $finish;
    end

endmodule

>>> fixed_point_alu.f
sv/fpa_pkg.sv
sv/fpa_front.sv
sv/fpa_queue.sv
sv/fpa_back.sv
sv/fixed_point_alu.sv
sim/fixed_point_alu_checker.sv
sim/fixed_point_alu_tb.sv
